[src/rhc_pkg.sv]
package rhc_pkg;

    // input transaction: one rgb pixel
    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_t;

    // output transaction: one hsv pixel
    typedef struct packed {
        logic [15:0] hue_out;
        logic [15:0] sat_out;
        logic [7:0]  val_out;
    } hsv_t;

    // classified pixel passed from front end to back end
    // hue_num is the hue numerator folded into one turn, hue_den is 6*(max-min)
    typedef struct packed {
        logic [7:0]  val;
        logic [7:0]  delta;
        logic [10:0] hue_num;
        logic [10:0] hue_den;
        logic        gray;
        logic        black;
    } cls_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

endpackage

[src/rhc_front.sv]
module rhc_front (
    input  rhc_pkg::pixel_t pixel,
    output rhc_pkg::cls_t   cls
);

    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [7:0]  delta;
    logic [11:0] d12;
    logic [11:0] den12;
    logic [11:0] num12;

    assign r = pixel.red_in;
    assign g = pixel.green_in;
    assign b = pixel.blue_in;

    // largest and smallest channel
    always_comb
    begin
        mx = r;
        if (g > mx)
        begin
            mx = g;
        end
        if (b > mx)
        begin
            mx = b;
        end
        mn = r;
        if (g < mn)
        begin
            mn = g;
        end
        if (b < mn)
        begin
            mn = b;
        end
    end

    assign delta = mx - mn;
    assign d12   = {4'd0, delta};
    assign den12 = (d12 << 2) + (d12 << 1);

    // hue numerator by sector, folded into [0, 6d)
    always_comb
    begin
        if (mx == r)
        begin
            if (g >= b)
            begin
                num12 = {4'd0, g - b};
            end
            else
            begin
                num12 = den12 - {4'd0, b - g};
            end
        end
        else if (mx == g)
        begin
            num12 = (d12 << 1) + {4'd0, b} - {4'd0, r};
        end
        else
        begin
            num12 = (d12 << 2) + {4'd0, r} - {4'd0, g};
        end
    end

    assign cls.val     = mx;
    assign cls.delta   = delta;
    assign cls.hue_num = num12[10:0];
    assign cls.hue_den = den12[10:0];
    assign cls.gray    = (delta == 8'd0);
    assign cls.black   = (mx == 8'd0);

endmodule

[src/rhc_queue.sv]
module rhc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  rhc_pkg::cls_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output rhc_pkg::cls_t rd_data,
    output logic          valid
);

    localparam int PB = rhc_pkg::QUEUE_PTR_BITS;

    rhc_pkg::cls_t     mem_reg [rhc_pkg::QUEUE_DEPTH];
    logic [PB-1:0]     wr_ptr_reg;
    logic [PB-1:0]     wr_ptr_next;
    logic [PB-1:0]     rd_ptr_reg;
    logic [PB-1:0]     rd_ptr_next;
    logic [PB:0]       count_reg;
    logic [PB:0]       count_next;

    assign full    = (count_reg == (PB + 1)'(rhc_pkg::QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (wr_en ? PB'(1) : PB'(0));
        rd_ptr_next = rd_ptr_reg + (rd_en ? PB'(1) : PB'(0));
        count_next  = count_reg + (wr_en ? (PB + 1)'(1) : (PB + 1)'(0))
                      - (rd_en ? (PB + 1)'(1) : (PB + 1)'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[src/rhc_back.sv]
module rhc_back #(
    parameter int HUE_BITS = 16,
    parameter int SAT_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  rhc_pkg::cls_t q_data,
    output logic          q_read,
    output logic          empty,
    input  logic          pop,
    output rhc_pkg::hsv_t result
);

    localparam int DEPTH = (HUE_BITS > SAT_BITS) ? HUE_BITS : SAT_BITS;

    typedef struct packed {
        logic [7:0]          val;
        logic                gray;
        logic                black;
        logic [10:0]         hue_den;
        logic [10:0]         hue_rem;
        logic [7:0]          sat_rem;
        logic [SAT_BITS-1:0] sat_low;
        logic [HUE_BITS-1:0] hue_q;
        logic [SAT_BITS-1:0] sat_q;
    } stage_t;

    stage_t              stage_reg [DEPTH];
    stage_t              head;
    logic [DEPTH-1:0]    valid_reg;
    logic [DEPTH-1:0]    valid_next;
    logic                advance;
    logic [SAT_BITS+7:0] sat_num;

    // whole pipe moves unless the finished transaction is held
    assign advance = !valid_reg[DEPTH-1] || pop;
    assign q_read  = advance && q_valid;
    assign empty   = !valid_reg[DEPTH-1];

    // saturation numerator (2^S - 1) * d
    assign sat_num = ({{SAT_BITS{1'b0}}, q_data.delta} << SAT_BITS)
                     - {{SAT_BITS{1'b0}}, q_data.delta};

    // first stage loads from the queue
    always_comb
    begin
        head.val     = q_data.val;
        head.gray    = q_data.gray;
        head.black   = q_data.black;
        head.hue_den = q_data.hue_den;
        head.hue_rem = q_data.hue_num;
        head.sat_rem = sat_num[SAT_BITS+7:SAT_BITS];
        head.sat_low = sat_num[SAT_BITS-1:0];
        head.hue_q   = '0;
        head.sat_q   = '0;
    end

    // one quotient bit of each division per stage, up to that division's width
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_stage
        stage_t      cur;
        stage_t      nxt;
        logic [11:0] hue_shift;
        logic        hue_ge;
        logic [8:0]  sat_shift;
        logic        sat_ge;

        if (k > 0)
        begin : g_link
            assign cur = stage_reg[k-1];
        end
        else
        begin : g_head
            assign cur = head;
        end

        assign hue_shift = {cur.hue_rem, 1'b0};
        assign hue_ge    = (hue_shift >= {1'b0, cur.hue_den});
        assign sat_shift = {cur.sat_rem, cur.sat_low[SAT_BITS-1]};
        assign sat_ge    = (sat_shift >= {1'b0, cur.val});

        always_comb
        begin
            nxt = cur;
            if (k < HUE_BITS)
            begin
                nxt.hue_rem = hue_ge
                    ? 11'(hue_shift - {1'b0, cur.hue_den})
                    : hue_shift[10:0];
                nxt.hue_q = {cur.hue_q[HUE_BITS-2:0], hue_ge};
            end
            if (k < SAT_BITS)
            begin
                nxt.sat_rem = sat_ge
                    ? 8'(sat_shift - {1'b0, cur.val})
                    : sat_shift[7:0];
                nxt.sat_low = cur.sat_low << 1;
                nxt.sat_q   = {cur.sat_q[SAT_BITS-2:0], sat_ge};
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                stage_reg[k] <= nxt;
            end
        end
    end

    // valid bits travel with the stages
    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = {valid_reg[DEPTH-2:0], q_valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // gray and black pixels force hue and saturation to zero
    assign result.hue_out = stage_reg[DEPTH-1].gray ? 16'd0 : 16'(stage_reg[DEPTH-1].hue_q);
    assign result.sat_out = stage_reg[DEPTH-1].black ? 16'd0 : 16'(stage_reg[DEPTH-1].sat_q);
    assign result.val_out = stage_reg[DEPTH-1].val;

endmodule

[src/rgb_to_hsv_converter.sv]
// path: a transaction taken is written into the queue, then passes through the divider
// pipeline registers to the result ports. throughput: one pixel per cycle while results
// are popped; a 4-entry queue lets the intake run on during a stall
// reset: rst_n clears queue pointers and pipeline valid bits at once, no clearing pass
module rgb_to_hsv_converter #(
    parameter int HUE_BITS = 16,
    parameter int SAT_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  rhc_pkg::pixel_t pixel,
    output logic            empty,
    input  logic            pop,
    output rhc_pkg::hsv_t   result
);

    rhc_pkg::cls_t front_cls;
    rhc_pkg::cls_t queue_data;
    logic          queue_valid;
    logic          queue_read;
    logic          queue_write;

    assign queue_write = push && !full;

    // classify the incoming transaction
    rhc_front u_front (
        .pixel (pixel),
        .cls   (front_cls)
    );

    // decoupling queue
    rhc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (queue_write),
        .wr_data (front_cls),
        .full    (full),
        .rd_en   (queue_read),
        .rd_data (queue_data),
        .valid   (queue_valid)
    );

    // pipelined dividers
    rhc_back #(
        .HUE_BITS (HUE_BITS),
        .SAT_BITS (SAT_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (queue_valid),
        .q_data  (queue_data),
        .q_read  (queue_read),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
